// ===== rtl/core/pslc_pkg.sv =====
`default_nettype none
package pslc_pkg;
  localparam int LINE_LEN = 11;
  localparam int POS_W = $clog2(LINE_LEN + 1);

  typedef enum logic [2:0] {
    F_RX    = 3'd0,
    F_TICK  = 3'd1,
    F_CMD   = 3'd2,
    F_SHUT  = 3'd3,
    F_POWER = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    K_TX     = 2'd0,
    K_REPORT = 2'd1,
    K_RELAY  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    J_NONE   = 2'd0,
    J_REPORT = 2'd1,
    J_CMD    = 2'd2,
    J_LAMPQ  = 2'd3
  } job_kind_t;

  typedef enum logic [1:0] {
    PQ_LAMP = 2'd0,
    PQ_SRC  = 2'd2,
    PQ_NONE = 2'd3
  } pq_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_RUN  = 2'd1,
    B_FIN  = 2'd2
  } bstate_t;

  // job: one front decision for the back part to stream out
  typedef struct packed {
    job_kind_t   jk;
    logic        src_q;      // lamp-query job variant: source query
    logic [2:0]  rid;
    logic [1:0]  rlen;
    logic [13:0] rval;
    logic        relay;      // relay-off after the report
    logic [6:0]  code;       // command code
  } job_t;

  localparam int QDEPTH = 2;

  function automatic logic [7:0] cmd_code(input logic [3:0] i);
    case (i)
      4'd0: cmd_code = 8'd1;   4'd1: cmd_code = 8'd2;
      4'd2: cmd_code = 8'd47;  4'd3: cmd_code = 8'd30;
      4'd4: cmd_code = 8'd31;  4'd5: cmd_code = 8'd15;
      4'd6: cmd_code = 8'd18;  4'd7: cmd_code = 8'd19;
      4'd8: cmd_code = 8'd50;  4'd9: cmd_code = 8'd8;
      4'd10: cmd_code = 8'd9;  4'd11: cmd_code = 8'd10;
      4'd12: cmd_code = 8'd11; 4'd13: cmd_code = 8'd12;
      default: cmd_code = 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] lamp_q(input logic [3:0] i);
    case (i)
      4'd0: lamp_q = "*"; 4'd1: lamp_q = " "; 4'd2: lamp_q = "0";
      4'd3: lamp_q = " "; 4'd4: lamp_q = "L"; 4'd5: lamp_q = "a";
      4'd6: lamp_q = "m"; 4'd7: lamp_q = "p"; 4'd8: lamp_q = " ";
      4'd9: lamp_q = "?"; default: lamp_q = 8'h0d;
    endcase
  endfunction

  function automatic logic [7:0] src_q(input logic [3:0] i);
    case (i)
      4'd0: src_q = "*"; 4'd1: src_q = " "; 4'd2: src_q = "0";
      4'd3: src_q = " "; 4'd4: src_q = "S"; 4'd5: src_q = "r";
      4'd6: src_q = "c"; 4'd7: src_q = " "; 4'd8: src_q = "?";
      default: src_q = 8'h0d;
    endcase
  endfunction

  function automatic logic [7:0] cmd_pre(input logic [3:0] i);
    case (i)
      4'd0: cmd_pre = "*"; 4'd1: cmd_pre = " "; 4'd2: cmd_pre = "0";
      4'd3: cmd_pre = " "; 4'd4: cmd_pre = "I"; 4'd5: cmd_pre = "R";
      4'd6: cmd_pre = " "; default: cmd_pre = "0";
    endcase
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    is_dig = (c >= 8'h30) && (c <= 8'h39);
  endfunction
endpackage
`default_nettype wire

// ===== rtl/core/pslc_front.sv =====
`default_nettype none
module pslc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  output logic                   full,
  input  wire logic [2:0]        func,
  input  wire logic [7:0]        arg,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [5:0]        cfg_data,
  output pslc_pkg::job_t         job,
  output logic                   job_valid,
  input  wire logic              job_ready
);
  logic [5:0] poll_limit, source_query_point;
  logic [7:0] line_store [pslc_pkg::LINE_LEN];
  logic [pslc_pkg::POS_W-1:0] line_pos;
  logic lamp_on, shutdown_pending, power_on;
  logic [7:0] current_source;
  logic [1:0] pending_query;
  logic [5:0] tick_count;

  logic take;
  logic [7:0] b [pslc_pkg::LINE_LEN];
  logic [pslc_pkg::POS_W-1:0] pos_w, pos_inc;
  logic eol;
  logic [13:0] hours;
  logic [7:0] dv;
  logic lamp_next;
  logic [7:0] src_next;
  logic [5:0] tick_next;
  logic lq, sq;

  assign full = job_valid && !job_ready;
  assign take = push && !full;

  always_comb begin
    pos_w = (line_pos >= pslc_pkg::POS_W'(pslc_pkg::LINE_LEN)) ? '0 : line_pos;
    pos_inc = pos_w + 1'b1;
    for (int i = 0; i < pslc_pkg::LINE_LEN; i++)
      b[i] = (pslc_pkg::POS_W'(i) == pos_w) ? arg : line_store[i];
    eol = (arg == 8'h0d) || (pos_inc == pslc_pkg::POS_W'(pslc_pkg::LINE_LEN));
    hours = '0;
    if (pslc_pkg::is_dig(b[0])) begin
      hours = 14'(b[0] - 8'h30);
      if (pslc_pkg::is_dig(b[1])) begin
        hours = 14'(hours * 10 + 14'(b[1] - 8'h30));
        if (pslc_pkg::is_dig(b[2])) begin
          hours = 14'(hours * 10 + 14'(b[2] - 8'h30));
          if (pslc_pkg::is_dig(b[3]))
            hours = 14'(hours * 10 + 14'(b[3] - 8'h30));
        end
      end
    end
    dv = b[3] - 8'h30;
    lamp_next = (b[5] == "0") ? 1'b0 : (b[5] == "1") ? 1'b1 : lamp_on;
    src_next = b[4] - 8'h30;
    lq = power_on && (tick_count > poll_limit);
    tick_next = lq ? 6'd0 : power_on ? tick_count + 6'd1 : tick_count;
    sq = !lq && shutdown_pending && !lamp_on && (tick_next == source_query_point);
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_ready) job_valid <= 1'b0;
    if (cfg_we) begin
      if (cfg_index == 1'b0) poll_limit <= cfg_data;
      else source_query_point <= cfg_data;
    end
    if (take) begin
      job <= '0;
      case (pslc_pkg::func_t'(func))
        pslc_pkg::F_RX: begin
          line_pos <= eol ? '0 : pos_inc;
          for (int i = 0; i < pslc_pkg::LINE_LEN; i++) line_store[i] <= b[i];
          if (eol) begin
            case (b[0])
              "R": ;
              "L": if (b[1] == "a" && b[2] == "m" && b[3] == "p") begin
                lamp_on <= lamp_next;
                job_valid <= 1'b1;
                job.jk <= pslc_pkg::J_REPORT;
                job.rid <= 3'd1; job.rlen <= 2'd2; job.rval <= 14'(lamp_next);
              end
              "S": if (b[1] == "r" && b[2] == "c") begin
                current_source <= src_next;
                job_valid <= 1'b1;
                job.jk <= pslc_pkg::J_REPORT;
                job.rid <= 3'd2; job.rlen <= 2'd2; job.rval <= 14'(src_next);
                if (shutdown_pending && !lamp_on && src_next != 0) begin
                  job.relay <= 1'b1; shutdown_pending <= 1'b0;
                end
              end
              "*": begin
                job_valid <= 1'b1;
                job.jk <= pslc_pkg::J_REPORT;
                job.rid <= 3'd5; job.rlen <= 2'd2; job.rval <= 14'(dv);
                if (pending_query == pslc_pkg::PQ_SRC && dv == 8'd1
                    && shutdown_pending && !lamp_on) begin
                  job.relay <= 1'b1; shutdown_pending <= 1'b0;
                end
                pending_query <= pslc_pkg::PQ_NONE;
              end
              default: if (pslc_pkg::is_dig(b[0]) && pslc_pkg::is_dig(b[1])) begin
                line_store[4] <= 8'd0;
                job_valid <= 1'b1;
                job.jk <= pslc_pkg::J_REPORT;
                job.rid <= 3'd3; job.rlen <= 2'd3; job.rval <= hours;
              end
            endcase
          end
        end
        pslc_pkg::F_TICK: begin
          tick_count <= tick_next;
          if (lq) begin
            pending_query <= pslc_pkg::PQ_LAMP;
            job_valid <= 1'b1; job.jk <= pslc_pkg::J_LAMPQ;
          end else if (sq) begin
            pending_query <= pslc_pkg::PQ_SRC;
            job_valid <= 1'b1; job.jk <= pslc_pkg::J_LAMPQ; job.src_q <= 1'b1;
          end
        end
        pslc_pkg::F_CMD: if (arg < 8'd13) begin
          job_valid <= 1'b1; job.jk <= pslc_pkg::J_CMD;
          job.code <= (arg == 8'd0) ? (lamp_on ? 7'd2 : 7'd1)
                    : 7'(pslc_pkg::cmd_code(4'(arg + 8'd1)));
        end
        pslc_pkg::F_SHUT: begin
          shutdown_pending <= 1'b1;
          if (power_on && lamp_on) begin
            job_valid <= 1'b1; job.jk <= pslc_pkg::J_CMD; job.code <= 7'd2;
          end
        end
        pslc_pkg::F_POWER: power_on <= (arg != 8'd0);
        default: ;
      endcase
    end
    if (rst) begin
      poll_limit <= 6'd50; source_query_point <= 6'd20;
      for (int i = 0; i < pslc_pkg::LINE_LEN; i++) line_store[i] <= 8'd0;
      line_pos <= '0; lamp_on <= 1'b0; current_source <= 8'd0;
      pending_query <= pslc_pkg::PQ_NONE; tick_count <= 6'd0;
      shutdown_pending <= 1'b0; power_on <= 1'b0; job_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/pslc_back.sv =====
`default_nettype none
module pslc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire pslc_pkg::job_t job,
  input  wire logic          job_valid,
  output logic               job_ready,
  output logic               empty,
  input  wire logic          pop,
  output logic [1:0]         kind,
  output logic [7:0]         tx_byte,
  output logic [2:0]         report_id,
  output logic [1:0]         report_len,
  output logic [13:0]        report_value,
  output logic               last
);
  pslc_pkg::job_t cur;
  logic busy;
  logic [3:0] idx;
  logic [3:0] nlast;
  logic [7:0] byte_w;
  logic emit;
  logic [6:0] tens;

  assign job_ready = !busy;
  assign emit = busy && (empty || pop);

  always_comb begin
    tens = (cur.code >= 7'd50) ? 7'd5 : (cur.code >= 7'd40) ? 7'd4 :
           (cur.code >= 7'd30) ? 7'd3 : (cur.code >= 7'd20) ? 7'd2 :
           (cur.code >= 7'd10) ? 7'd1 : 7'd0;
    nlast = 4'd0;
    byte_w = 8'd0;
    case (cur.jk)
      pslc_pkg::J_REPORT: nlast = cur.relay ? 4'd1 : 4'd0;
      pslc_pkg::J_CMD: begin
        nlast = 4'd10;
        if (idx < 4'd8) byte_w = pslc_pkg::cmd_pre(idx);
        else if (idx == 4'd8) byte_w = 8'h30 + 8'(tens);
        else if (idx == 4'd9) byte_w = 8'h30 + 8'(cur.code - 7'(tens * 10));
        else byte_w = 8'h0d;
      end
      pslc_pkg::J_LAMPQ: begin
        nlast = cur.src_q ? 4'd9 : 4'd10;
        byte_w = cur.src_q ? pslc_pkg::src_q(idx) : pslc_pkg::lamp_q(idx);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop && !empty) empty <= 1'b1;
    if (!busy && job_valid) begin
      cur <= job; busy <= 1'b1; idx <= 4'd0;
    end
    if (emit) begin
      empty <= 1'b0;
      last <= (idx == nlast);
      tx_byte <= 8'd0; report_id <= 3'd0; report_len <= 2'd0; report_value <= 14'd0;
      if (cur.jk == pslc_pkg::J_REPORT && idx == 4'd0) begin
        kind <= pslc_pkg::K_REPORT;
        report_id <= cur.rid; report_len <= cur.rlen; report_value <= cur.rval;
      end else if (cur.jk == pslc_pkg::J_REPORT) begin
        kind <= pslc_pkg::K_RELAY;
      end else begin
        kind <= pslc_pkg::K_TX; tx_byte <= byte_w;
      end
      idx <= idx + 4'd1;
      if (idx == nlast) busy <= 1'b0;
    end
    if (rst) begin
      busy <= 1'b0; empty <= 1'b1;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/projector_serial_link_controller.sv =====
`default_nettype none
// Projector serial-link controller.
// Input channel: push/full with func and arg; one item per accepted push.
// Config: cfg_we writes cfg_index (0 poll_limit, 1 source_query_point)
// from cfg_data; users must write only while idle (the block never checks).
// Result channel: empty/pop; kind, tx_byte, report fields and last show the
// oldest result while empty is low; last flags the final result of an item.
// The front part decodes an item and holds one decoded job; the back part
// loads that job once idle and streams it out, one result per cycle while
// the result channel is empty or popped.
// A command or query gives 11 (source query 10) bytes, a report one or two
// results. An item passes the front job register and the back part's
// current-job register before its results reach the output registers;
// the back part loads a new job only after the last result of its job.
// A stalled result (pop low) holds the back part; the front part keeps
// taking items until its job register is full, then raises full.
// Reset (rst, synchronous) clears control state, restores config defaults.
module projector_serial_link_controller (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  func,
  input  wire logic [7:0]  arg,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [5:0]  cfg_data,
  output logic             empty,
  input  wire logic        pop,
  output logic [1:0]       kind,
  output logic [7:0]       tx_byte,
  output logic [2:0]       report_id,
  output logic [1:0]       report_len,
  output logic [13:0]      report_value,
  output logic             last
);
  pslc_pkg::job_t job;
  logic job_valid, job_ready;

  pslc_front u_front (
    .clk, .rst, .push, .full, .func, .arg, .cfg_we, .cfg_index, .cfg_data,
    .job, .job_valid, .job_ready
  );

  pslc_back u_back (
    .clk, .rst, .job, .job_valid, .job_ready, .empty, .pop, .kind, .tx_byte,
    .report_id, .report_len, .report_value, .last
  );
endmodule
`default_nettype wire
